// ===== rtl/amrf_pkg.sv =====
// amrf_pkg: shared types, constants and codes for the approximate motif read filter.
// Used by every module under rtl; depends on nothing.
package amrf_pkg;

  localparam int SHORT_LEN_DEF  = 5;
  localparam int STRICT_LEN_DEF = 10;
  localparam int MAX_MOTIFS_DEF = 16;

  localparam logic [7:0] HEADER_MARK_A = 8'h3E;  // '>'
  localparam logic [7:0] HEADER_MARK_B = 8'h40;  // '@'

  // request codes
  localparam logic [1:0] REQ_LOAD_SHORT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_STRICT = 2'd1;
  localparam logic [1:0] REQ_READ_CHAR   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SHORT_COUNT   = 2'd0;
  localparam logic [1:0] REG_STRICT_COUNT  = 2'd1;
  localparam logic [1:0] REG_SHORT_MARGIN  = 2'd2;
  localparam logic [1:0] REG_STRICT_MARGIN = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] entry_index;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic keep;
    logic short_hit;
    logic strict_hit;
  } out_item_t;

  typedef struct packed {
    logic [4:0] short_count;
    logic [4:0] strict_count;
    logic [2:0] short_margin;
    logic [3:0] strict_margin;
  } cfg_t;

  typedef struct packed {
    logic load_short;
    logic load_strict;
    logic char_step;
    logic clear_line;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       eol;
    logic       hdr_now;
    logic       scan_last;
  } status_t;

endpackage

// ===== rtl/amrf_regs.sv =====
// amrf_regs: APB-style configuration registers (counts and margins).
// Depends on amrf_pkg.
module amrf_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output amrf_pkg::cfg_t     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        amrf_pkg::REG_SHORT_COUNT:   cfg.short_count   <= pwdata[4:0];
        amrf_pkg::REG_STRICT_COUNT:  cfg.strict_count  <= pwdata[4:0];
        amrf_pkg::REG_SHORT_MARGIN:  cfg.short_margin  <= pwdata[2:0];
        amrf_pkg::REG_STRICT_MARGIN: cfg.strict_margin <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      amrf_pkg::REG_SHORT_COUNT:   prdata = {27'd0, cfg.short_count};
      amrf_pkg::REG_STRICT_COUNT:  prdata = {27'd0, cfg.strict_count};
      amrf_pkg::REG_SHORT_MARGIN:  prdata = {29'd0, cfg.short_margin};
      amrf_pkg::REG_STRICT_MARGIN: prdata = {28'd0, cfg.strict_margin};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/amrf_dp.sv =====
// amrf_dp: datapath - motif memories, sliding window, line flags, entry scan
// and Hamming compare, result register. Depends on amrf_pkg.
module amrf_dp #(
  parameter int SHORT_LEN  = amrf_pkg::SHORT_LEN_DEF,
  parameter int STRICT_LEN = amrf_pkg::STRICT_LEN_DEF,
  parameter int MAX_MOTIFS = amrf_pkg::MAX_MOTIFS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  amrf_pkg::in_item_t  in_data,
  input  amrf_pkg::cfg_t      cfg,
  input  amrf_pkg::cmd_t      cmd,
  output amrf_pkg::status_t   status,
  output amrf_pkg::out_item_t out_data
);

  localparam int WIN_LEN = (SHORT_LEN > STRICT_LEN) ? SHORT_LEN : STRICT_LEN;
  localparam int IDX_W   = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
  localparam int SPW     = (SHORT_LEN > 1) ? $clog2(SHORT_LEN) : 1;
  localparam int TPW     = (STRICT_LEN > 1) ? $clog2(STRICT_LEN) : 1;
  localparam int FW      = $clog2(WIN_LEN + 1);
  localparam int SDW     = $clog2(SHORT_LEN + 1);
  localparam int TDW     = $clog2(STRICT_LEN + 1);
  localparam int SCW     = (SDW > 3) ? SDW : 3;
  localparam int TCW     = (TDW > 4) ? TDW : 4;
  localparam int CNW     = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

  logic [SHORT_LEN-1:0][7:0]  short_mem  [MAX_MOTIFS];
  logic [STRICT_LEN-1:0][7:0] strict_mem [MAX_MOTIFS];
  logic [SHORT_LEN-1:0][7:0]  short_row;
  logic [STRICT_LEN-1:0][7:0] strict_row;

  logic [WIN_LEN-1:0][7:0] win;
  logic [WIN_LEN-1:0][7:0] win_next;
  logic [FW-1:0]           fill;
  logic                    at_line_start;
  logic                    in_header;
  logic                    short_found;
  logic                    strict_found;
  logic [IDX_W-1:0]        idx;
  logic                    short_cmp_v;
  logic                    strict_cmp_v;

  logic [IDX_W+3:0] ent_ext;
  logic [SPW+3:0]   spos_ext;
  logic [TPW+3:0]   tpos_ext;
  logic             ent_ok;
  logic             is_mark;
  logic [SDW-1:0]   short_diff;
  logic [TDW-1:0]   strict_diff;
  logic             short_hit_now;
  logic             strict_hit_now;

  assign ent_ext  = {{IDX_W{1'b0}}, in_data.entry_index};
  assign spos_ext = {{SPW{1'b0}}, in_data.char_position};
  assign tpos_ext = {{TPW{1'b0}}, in_data.char_position};
  assign ent_ok   = ent_ext < (IDX_W + 4)'(MAX_MOTIFS);
  assign is_mark  = (in_data.char_value == amrf_pkg::HEADER_MARK_A) ||
                    (in_data.char_value == amrf_pkg::HEADER_MARK_B);

  assign status.req_type  = in_data.req_type;
  assign status.eol       = in_data.end_of_line;
  assign status.hdr_now   = at_line_start ? is_mark : in_header;
  assign status.scan_last = (idx == IDX_W'(MAX_MOTIFS - 1));

  // motif memories: byte-lane writes, one row read per cycle while scanning
  always_ff @(posedge clk) begin
    if (cmd.load_short && ent_ok && spos_ext < (SPW + 4)'(SHORT_LEN)) begin
      short_mem[ent_ext[IDX_W-1:0]][spos_ext[SPW-1:0]] <= in_data.char_value;
    end
    if (cmd.load_strict && ent_ok && tpos_ext < (TPW + 4)'(STRICT_LEN)) begin
      strict_mem[ent_ext[IDX_W-1:0]][tpos_ext[TPW-1:0]] <= in_data.char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      short_row  <= short_mem[idx];
      strict_row <= strict_mem[idx];
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[WIN_LEN-1] = in_data.char_value;
  end

  always_comb begin
    short_diff = '0;
    for (int k = 0; k < SHORT_LEN; k++) begin
      short_diff = short_diff +
                   SDW'(win[WIN_LEN-SHORT_LEN+k] != short_row[k]);
    end
    strict_diff = '0;
    for (int k = 0; k < STRICT_LEN; k++) begin
      strict_diff = strict_diff +
                    TDW'(win[WIN_LEN-STRICT_LEN+k] != strict_row[k]);
    end
    short_hit_now  = short_cmp_v && (SCW'(short_diff) < SCW'(cfg.short_margin));
    strict_hit_now = strict_cmp_v && (TCW'(strict_diff) < TCW'(cfg.strict_margin));
  end

  always_ff @(posedge clk) begin
    if (cmd.char_step && !status.hdr_now) begin
      win <= win_next;
    end
    if (cmd.emit) begin
      out_data.keep       <= short_found && strict_found;
      out_data.short_hit  <= short_found;
      out_data.strict_hit <= strict_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      at_line_start <= 1'b1;
      in_header     <= 1'b0;
      short_found   <= 1'b0;
      strict_found  <= 1'b0;
      idx           <= '0;
      short_cmp_v   <= 1'b0;
      strict_cmp_v  <= 1'b0;
    end else begin
      short_cmp_v  <= cmd.scan && (CNW'(idx) < CNW'(cfg.short_count)) &&
                      (fill >= FW'(SHORT_LEN));
      strict_cmp_v <= cmd.scan && (CNW'(idx) < CNW'(cfg.strict_count)) &&
                      (fill >= FW'(STRICT_LEN));
      if (cmd.char_step) begin
        idx <= '0;
      end else if (cmd.scan) begin
        idx <= idx + 1'b1;
      end
      if (cmd.clear_line || cmd.emit) begin
        fill          <= '0;
        at_line_start <= 1'b1;
        in_header     <= 1'b0;
        short_found   <= 1'b0;
        strict_found  <= 1'b0;
      end else begin
        if (short_hit_now) begin
          short_found <= 1'b1;
        end
        if (strict_hit_now) begin
          strict_found <= 1'b1;
        end
        if (cmd.char_step) begin
          at_line_start <= 1'b0;
          in_header     <= status.hdr_now;
          if (!status.hdr_now && fill != FW'(WIN_LEN)) begin
            fill <= fill + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/amrf_ctrl.sv =====
// amrf_ctrl: controller state machine - input/output handshake, scan
// sequencing and result hand-off. Depends on amrf_pkg.
module amrf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  amrf_pkg::status_t status,
  output amrf_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT} state_t;

  state_t state;
  logic   eol_pend;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (status.req_type)
            amrf_pkg::REQ_LOAD_SHORT:  cmd.load_short = 1'b1;
            amrf_pkg::REQ_LOAD_STRICT: cmd.load_strict = 1'b1;
            amrf_pkg::REQ_READ_CHAR: begin
              cmd.char_step  = 1'b1;
              cmd.clear_line = status.hdr_now && status.eol;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_EMIT: cmd.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
      eol_pend  <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && status.req_type == amrf_pkg::REQ_READ_CHAR && !status.hdr_now) begin
            state    <= ST_SCAN;
            in_stall <= 1'b1;
            eol_pend <= status.eol;
          end
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (eol_pend) begin
            state <= ST_EMIT;
          end else begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/approx_motif_read_filter_core.sv =====
// approx_motif_read_filter_core: top level of the approximate motif read filter.
// Depends on amrf_pkg, amrf_regs, amrf_ctrl and amrf_dp.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data  (amrf_pkg::in_item_t)
//   out      output     out_valid/out_stall  out_data (amrf_pkg::out_item_t)
//   cfg      input      APB psel/penable     paddr, pwdata, prdata
//
// Load, header and unused transactions complete in their accept cycle. A read
// character passes the accept cycle, then both motif memories scanned one entry
// per cycle on their single read ports, then a compare cycle; end of a
// non-header line then hands the result to the output register, waiting while
// an earlier result still waits there stalled. Reset is synchronous and needs
// no clearing pass; motif memories are undefined until loaded.
module approx_motif_read_filter_core #(
  parameter int SHORT_LEN  = amrf_pkg::SHORT_LEN_DEF,
  parameter int STRICT_LEN = amrf_pkg::STRICT_LEN_DEF,
  parameter int MAX_MOTIFS = amrf_pkg::MAX_MOTIFS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  amrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output amrf_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  amrf_pkg::cfg_t    cfg;
  amrf_pkg::cmd_t    cmd;
  amrf_pkg::status_t status;

  amrf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  amrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  amrf_dp #(
    .SHORT_LEN  (SHORT_LEN),
    .STRICT_LEN (STRICT_LEN),
    .MAX_MOTIFS (MAX_MOTIFS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for approx_motif_read_filter_core.
// Drives motif loads and read characters, models the Hamming-distance scan and
// checks each verdict. Depends on amrf_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLEN = amrf_pkg::SHORT_LEN_DEF;
  localparam int TLEN = amrf_pkg::STRICT_LEN_DEF;
  localparam int MAXM = amrf_pkg::MAX_MOTIFS_DEF;
  localparam int WLEN = (SLEN > TLEN) ? SLEN : TLEN;
  localparam int IN_W = $bits(amrf_pkg::in_item_t);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE_ITEMS = 120;
  localparam int DRAIN_CYCLES = 2 * MAXM + 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_PROBES = 23;

  typedef struct packed {
    amrf_pkg::in_item_t  item;
    logic                pinned;
    amrf_pkg::out_item_t want;
  } filter_probe_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  amrf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  amrf_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  approx_motif_read_filter_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state: table 0 = short motifs, table 1 = strict motifs
  logic [7:0]      motif_mem [2][MAXM][TLEN];
  bit [TLEN-1:0]   motif_loaded [2][MAXM];
  logic [4:0]      cfg_count [2];
  logic [3:0]      cfg_margin [2];
  logic [7:0]      win [WLEN];
  int              win_fill;
  bit              line_start, in_hdr, short_found, strict_found;

  amrf_pkg::out_item_t pending_verdicts [$];
  filter_probe_t       probes [N_PROBES];

  int unsigned cycles = 0;
  int mismatches = 0;
  int verdicts_checked = 0;
  int lines_scored = 0;
  int motif_writes = 0;
  int settings_run = 0;
  int random_items = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d verdicts outstanding", cycles,
             pending_verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  function automatic int motif_len(input int t);
    return t ? TLEN : SLEN;
  endfunction

  function automatic int entries_used(input int t);
    return (int'(cfg_count[t]) > MAXM) ? MAXM : int'(cfg_count[t]);
  endfunction

  function automatic logic [7:0] nucleotide(input int i);
    case (i)
      0: return 8'h41;
      1: return 8'h43;
      2: return 8'h47;
      default: return 8'h54;
    endcase
  endfunction

  function automatic void clear_line();
    foreach (win[i]) win[i] = '0;
    win_fill = 0;
    line_start = 1'b1;
    in_hdr = 1'b0;
    short_found = 1'b0;
    strict_found = 1'b0;
  endfunction

  function automatic bit table_hit(input int t);
    int len, diff;
    len = motif_len(t);
    for (int e = 0; e < entries_used(t); e++) begin
      diff = 0;
      for (int k = 0; k < len; k++)
        if (win[WLEN - len + k] != motif_mem[t][e][k]) diff++;
      if (diff < int'(cfg_margin[t])) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic advance_filter(input amrf_pkg::in_item_t it, output bit has,
                                output amrf_pkg::out_item_t v);
    int t;
    has = 1'b0;
    v = '0;
    case (it.req_type)
      amrf_pkg::REQ_LOAD_SHORT, amrf_pkg::REQ_LOAD_STRICT: begin
        t = int'(it.req_type == amrf_pkg::REQ_LOAD_STRICT);
        if (int'(it.char_position) < motif_len(t)) begin
          motif_mem[t][it.entry_index][it.char_position] = it.char_value;
          motif_loaded[t][it.entry_index][it.char_position] = 1'b1;
        end
      end
      amrf_pkg::REQ_READ_CHAR: begin
        if (line_start) begin
          line_start = 1'b0;
          in_hdr = (it.char_value == amrf_pkg::HEADER_MARK_A ||
                    it.char_value == amrf_pkg::HEADER_MARK_B);
        end
        if (!in_hdr) begin
          for (int i = 0; i < WLEN - 1; i++) win[i] = win[i + 1];
          win[WLEN - 1] = it.char_value;
          if (win_fill < WLEN) win_fill++;
          if (win_fill >= SLEN && table_hit(0)) short_found = 1'b1;
          if (win_fill >= TLEN && table_hit(1)) strict_found = 1'b1;
        end
        if (it.end_of_line) begin
          if (!in_hdr) begin
            has = 1'b1;
            v.keep = short_found && strict_found;
            v.short_hit = short_found;
            v.strict_hit = strict_found;
          end
          clear_line();
        end
      end
      default: ;
    endcase
  endtask

  // one input transaction; valid stays high into the next call unless a gap is drawn
  task automatic issue(input amrf_pkg::in_item_t it, input bit pinned,
                       input amrf_pkg::out_item_t pin_val);
    int unsigned gap;
    bit has;
    amrf_pkg::out_item_t v;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    advance_filter(it, has, v);
    if (it.req_type inside {amrf_pkg::REQ_LOAD_SHORT, amrf_pkg::REQ_LOAD_STRICT} &&
        int'(it.char_position) <
        motif_len(int'(it.req_type == amrf_pkg::REQ_LOAD_STRICT)))
      motif_writes++;
    if (has) begin
      pending_verdicts.push_back(pinned ? pin_val : v);
      lines_scored++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      amrf_pkg::REG_SHORT_COUNT:   cfg_count[0] = val[4:0];
      amrf_pkg::REG_STRICT_COUNT:  cfg_count[1] = val[4:0];
      amrf_pkg::REG_SHORT_MARGIN:  cfg_margin[0] = {1'b0, val[2:0]};
      amrf_pkg::REG_STRICT_MARGIN: cfg_margin[1] = val[3:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input int sc, input int tc, input int sm, input int tm);
    write_reg(amrf_pkg::REG_SHORT_COUNT, sc);
    write_reg(amrf_pkg::REG_STRICT_COUNT, tc);
    write_reg(amrf_pkg::REG_SHORT_MARGIN, sm);
    write_reg(amrf_pkg::REG_STRICT_MARGIN, tm);
    settings_run++;
  endtask

  task automatic load_motif_byte(input int t, input int e, input int p, input logic [7:0] ch);
    amrf_pkg::in_item_t it;
    it.req_type = t ? amrf_pkg::REQ_LOAD_STRICT : amrf_pkg::REQ_LOAD_SHORT;
    it.entry_index = 4'(e);
    it.char_position = 4'(p);
    it.char_value = ch;
    it.end_of_line = 1'($urandom_range(0, 1));
    issue(it, 1'b0, '0);
  endtask

  // every entry in use must be fully written before any read line is scanned
  task automatic fill_used_entries();
    for (int t = 0; t < 2; t++)
      for (int e = 0; e < entries_used(t); e++)
        for (int k = 0; k < motif_len(t); k++)
          if (!motif_loaded[t][e][k]) begin
            load_motif_byte(t, e, k, ($urandom_range(0, 19) == 0) ?
                            8'($urandom_range(0, 255)) : nucleotide($urandom_range(0, 3)));
            random_items++;
          end
  endtask

  task automatic send_read_line();
    logic [7:0] chars [32];
    int len, mlen, e, at;
    amrf_pkg::in_item_t it;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
    for (int i = 0; i < len; i++)
      chars[i] = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) :
                 nucleotide($urandom_range(0, 3));
    for (int t = 0; t < 2; t++) begin
      mlen = motif_len(t);
      if (entries_used(t) > 0 && len >= mlen && $urandom_range(0, 4) < 3) begin
        e = $urandom_range(0, entries_used(t) - 1);
        at = $urandom_range(0, len - mlen);
        for (int k = 0; k < mlen; k++)
          chars[at + k] = ($urandom_range(0, 4) == 0) ? nucleotide($urandom_range(0, 3)) :
                          motif_mem[t][e][k];
      end
    end
    if ($urandom_range(0, 11) == 0)
      chars[0] = $urandom_range(0, 1) ? amrf_pkg::HEADER_MARK_A : amrf_pkg::HEADER_MARK_B;
    for (int i = 0; i < len; i++) begin
      it.req_type = amrf_pkg::REQ_READ_CHAR;
      it.entry_index = 4'($urandom_range(0, 15));
      it.char_position = 4'($urandom_range(0, 15));
      it.char_value = chars[i];
      it.end_of_line = (i == len - 1);
      issue(it, 1'b0, '0);
      random_items++;
    end
  endtask

  function automatic filter_probe_t ld_row(input logic [1:0] rq, input int e, input int p,
                                           input logic [7:0] ch, input bit eol);
    filter_probe_t r;
    r = '0;
    r.item = {rq, 4'(e), 4'(p), ch, eol};
    return r;
  endfunction

  function automatic filter_probe_t rd_row(input logic [7:0] ch, input bit eol);
    return ld_row(amrf_pkg::REQ_READ_CHAR, 0, 0, ch, eol);
  endfunction

  function automatic filter_probe_t pin_row(input logic [7:0] ch, input bit k, input bit sh,
                                            input bit st);
    filter_probe_t r;
    r = rd_row(ch, 1'b1);
    r.pinned = 1'b1;
    r.want = {k, sh, st};
    return r;
  endfunction

  // output side: in idle phases, a random stall (possibly none) after each accepted verdict, plus stray stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall <= (stall_left != 0);
      end else if (out_idle) begin
        if (out_valid && !out_stall) begin
          stall_left = $urandom_range(0, 3);
          out_stall <= (stall_left != 0);
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 3);
          out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    amrf_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected verdict %b", out_data));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_data.keep !== want.keep)
          flag_mismatch($sformatf("keep got %b want %b", out_data.keep, want.keep));
        if (out_data.short_hit !== want.short_hit)
          flag_mismatch($sformatf("short_hit got %b want %b", out_data.short_hit,
                                  want.short_hit));
        if (out_data.strict_hit !== want.strict_hit)
          flag_mismatch($sformatf("strict_hit got %b want %b", out_data.strict_hit,
                                  want.strict_hit));
      end
    end
  end

  initial begin
    int phase, sc, tc, sm, tm, target;
    amrf_pkg::in_item_t it;
    clear_line();
    foreach (motif_loaded[t, e]) motif_loaded[t][e] = '0;
    foreach (motif_mem[t, e, k]) motif_mem[t][e][k] = '0;
    cfg_count[0] = '0;
    cfg_count[1] = '0;
    cfg_margin[0] = '0;
    cfg_margin[1] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one short motif "ACGTA", exact match only, no strict table
    set_filter(1, 0, 1, 0);
    probes = '{
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 0, 0, 8'h41, 1'b0),
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 0, 1, 8'h43, 1'b0),
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 0, 2, 8'h47, 1'b0),
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 0, 3, 8'h54, 1'b0),
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 0, 4, 8'h41, 1'b1),
      ld_row(amrf_pkg::REQ_LOAD_SHORT, 15, 15, 8'hFF, 1'b1),   // position out of range
      ld_row(amrf_pkg::REQ_LOAD_STRICT, 15, 10, 8'h00, 1'b0),  // position out of range
      pin_row(8'h41, 1'b0, 1'b0, 1'b0),                        // one-byte line
      rd_row(amrf_pkg::HEADER_MARK_A, 1'b0),                   // header line holding the motif
      rd_row(8'h41, 1'b0),
      rd_row(8'h43, 1'b0),
      rd_row(8'h47, 1'b0),
      rd_row(8'h54, 1'b0),
      rd_row(8'h41, 1'b1),
      rd_row(amrf_pkg::HEADER_MARK_B, 1'b1),                   // one-byte header
      rd_row(8'h41, 1'b0),
      rd_row(8'h43, 1'b0),
      ld_row(REQ_UNUSED, 15, 15, amrf_pkg::HEADER_MARK_A, 1'b1),
      rd_row(8'h47, 1'b0),
      rd_row(8'h54, 1'b0),
      pin_row(8'h41, 1'b0, 1'b1, 1'b0),                        // exact short hit
      rd_row(8'h00, 1'b0),
      pin_row(8'hFF, 1'b0, 1'b0, 1'b0)                         // too short to match
    };
    foreach (probes[i]) issue(probes[i].item, probes[i].pinned, probes[i].want);
    drain();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin sc = 16; tc = 16; sm = 7; tm = 15; end
        1: begin sc = 31; tc = 31; sm = 6; tm = 11; end
        2: begin sc = 1;  tc = 1;  sm = 1; tm = 1;  end
        3: begin sc = 0;  tc = 0;  sm = 0; tm = 0;  end
        4: begin sc = 17; tc = 16; sm = 0; tm = 3;  end
        default: begin
          sc = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
          tc = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
          sm = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
          tm = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
        end
      endcase
      in_idle = (phase % 3 != 2);
      out_idle = (phase % 3 != 2);
      set_filter(sc, tc, sm, tm);
      fill_used_entries();
      target = random_items + PHASE_ITEMS;
      while (random_items < target) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            repeat ($urandom_range(1, 4)) begin
              it.req_type = $urandom_range(0, 1) ? amrf_pkg::REQ_LOAD_STRICT :
                            amrf_pkg::REQ_LOAD_SHORT;
              it.entry_index = 4'($urandom_range(0, 15));
              it.char_position = 4'($urandom_range(0, 15));
              if (int'(it.char_position) <
                  motif_len(int'(it.req_type == amrf_pkg::REQ_LOAD_STRICT)))
                random_items++;
              load_motif_byte(int'(it.req_type == amrf_pkg::REQ_LOAD_STRICT),
                              int'(it.entry_index), int'(it.char_position),
                              ($urandom_range(0, 4) == 0) ?
                              8'($urandom_range(0, 255)) : nucleotide($urandom_range(0, 3)));
            end
          end
          2: begin
            it = amrf_pkg::in_item_t'(IN_W'($urandom()));
            it.req_type = REQ_UNUSED;
            issue(it, 1'b0, '0);
          end
          default: send_read_line();
        endcase
      end
      drain();
      phase++;
    end

    $display("Covered %0d register settings, %0d motif byte writes, %0d read lines scored",
             settings_run, motif_writes, lines_scored);
    $display("%0d verdicts checked, %0d mismatches, %0d cycles", verdicts_checked,
             mismatches, cycles);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
